>>> rtl/grfs_pkg.sv
// Shared types and constants for the gripper ramp sequencer.
// No dependencies; grfs_ctrl, grfs_dp and the core top level import this package.
`timescale 1ns / 1ps

package grfs_pkg;

   // Request type codes
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_OPEN  = 2'd1;
   localparam logic [1:0] REQ_CLOSE = 2'd2;
   localparam logic [1:0] REQ_RESET = 2'd3;

   // Sequencer mode codes
   localparam logic [2:0] MODE_START   = 3'd0;
   localparam logic [2:0] MODE_OPENING = 3'd1;
   localparam logic [2:0] MODE_CLOSING = 3'd2;
   localparam logic [2:0] MODE_HELD    = 3'd3;
   localparam logic [2:0] MODE_REOPEN  = 3'd4;

   // Control register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ANGLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGLE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSED_ANGLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_ANGLE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_PERIOD  = 3'd4;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [7:0]  MIN_ANGLE_RST    = 8'd0;
   localparam logic [7:0]  MAX_ANGLE_RST    = 8'd180;
   localparam logic [7:0]  CLOSED_ANGLE_RST = 8'd90;
   localparam logic [7:0]  OPEN_ANGLE_RST   = 8'd0;
   localparam logic [15:0] PERIOD_DEFAULT   = 16'd1000;

   // Ramp arithmetic
   localparam logic [7:0]  STEP_MAX  = 8'd180;
   localparam logic [23:0] SAT_Q     = 24'd181;  // quotient at or past this saturates
   localparam int          ELAP_W    = 24;       // elapsed width below saturation
   localparam int          PROD_W    = 32;       // span * elapsed
   localparam int          PERIOD_W  = 16;

   // Force filter
   localparam logic [7:0]  FORCE_THRESH = 8'd50;
   localparam logic [24:0] RECIP_TEN    = 25'd6554;  // 2^16 / 10, rounded up

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic mul_load;
      logic div_start;
      logic angle_apply;
      logic out_load;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_ramp;
      logic div_done;
   } dp_status_type;

endpackage

>>> rtl/grfs_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Uses only its own parameters; instantiated by grfs_dp.
`timescale 1ns / 1ps

module grfs_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [NUM_W-1:0] quot,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] denom_ff, denom_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;

   // Shift the next numerator bit into the partial remainder
   assign rem_sh = {rem_ff, quot_ff[NUM_W-1]};
   assign diff   = rem_sh - {1'b0, denom_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      denom_in = denom_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quot_in  = numer;
         denom_in = denom;
      end else if (busy_ff) begin
         // Subtract when it fits, record the quotient bit
         if (rem_sh >= {1'b0, denom_ff}) begin
            rem_in  = diff[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      denom_ff <= denom_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

>>> rtl/grfs_ctrl.sv
// Sequencing controller: handshakes and step order for each item.
// Depends on grfs_pkg for the command and status structs.
`timescale 1ns / 1ps

module grfs_ctrl
   import grfs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ctl_cmd_type   cmd,
   input  dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ANGLE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Commands follow the current state
   always_comb begin
      cmd             = '0;
      cmd.capture     = (state_ff == ST_IDLE) && req_valid;
      cmd.exec        = (state_ff == ST_EXEC);
      cmd.mul_load    = (state_ff == ST_MUL);
      cmd.div_start   = (state_ff == ST_DIV_GO);
      cmd.angle_apply = (state_ff == ST_ANGLE);
      cmd.out_load    = (state_ff == ST_DONE) && slot_free;
   end

   // Advance through the steps of one item
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_EXEC;
         ST_EXEC:     state_in = status.need_ramp ? ST_MUL : ST_DONE;
         ST_MUL:      state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (status.div_done) state_in = ST_ANGLE;
         ST_ANGLE:    state_in = ST_DONE;
         ST_DONE:     if (slot_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Hold the result valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/grfs_dp.sv
// Datapath: control registers, sequencer state, force filter, ramp math.
// Depends on grfs_pkg and instantiates grfs_div for the ramp division.
`timescale 1ns / 1ps

module grfs_dp
   import grfs_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   output dp_status_type         status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [1:0]            req_type,
   input  logic [31:0]           req_now_ms,
   input  logic [9:0]            req_fsr_raw,
   output logic [7:0]            rsp_servo_angle,
   output logic                  rsp_angle_written,
   output logic                  rsp_grabbed,
   output logic [2:0]            rsp_mode_now,
   output logic                  rsp_motion_active,
   output logic [7:0]            rsp_force_level
);

   localparam int CMP_W = (TIME_BITS > ELAP_W) ? TIME_BITS : ELAP_W;

   // Control registers
   logic [7:0]          min_ff, min_in;
   logic [7:0]          max_ff, max_in;
   logic [7:0]          closed_ff, closed_in;
   logic [7:0]          open_ff, open_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   // Sequencer state
   logic [2:0]           mode_ff, mode_in;
   logic                 running_ff, running_in;
   logic                 dir_up_ff, dir_up_in;
   logic                 holding_ff, holding_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [7:0]           last_ff, last_in;
   logic [7:0]           saved_ff, saved_in;
   logic [7:0]           force_ff, force_in;

   // Captured item and working values
   logic [1:0]           type_ff, type_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [9:0]           fsr_ff, fsr_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 sat_ff, sat_in;
   logic [7:0]           cmd_ff, cmd_in;
   logic                 wrote_ff, wrote_in;

   // Result registers
   logic [7:0] out_angle_ff, out_angle_in;
   logic       out_wrote_ff, out_wrote_in;
   logic       out_grab_ff, out_grab_in;
   logic [2:0] out_mode_ff, out_mode_in;
   logic       out_run_ff, out_run_in;
   logic [7:0] out_force_ff, out_force_in;

   // Force filter
   logic [17:0] raw_x255;
   logic [7:0]  force_scaled;
   logic [11:0] force_sum;
   logic [24:0] force_prod;
   logic [7:0]  force_new;
   logic        grab_hit;
   logic        grab_drop;
   logic [2:0]  mode_eff;

   // Ramp math
   logic [TIME_BITS-1:0] elapsed;
   logic [CMP_W-1:0]     elapsed_ext;
   logic [23:0]          sat_limit;
   logic [7:0]           span;
   logic [PROD_W-1:0]    quot;
   logic                 div_done;
   logic [7:0]           step;
   logic [7:0]           base;
   logic signed [9:0]    ramp_x;
   logic [7:0]           angle;

   // Scale sample to 0..254, then smooth as (3*new + 7*old) / 10
   assign raw_x255     = {fsr_ff, 8'd0} - 18'(fsr_ff);
   assign force_scaled = raw_x255[17:10];
   assign force_sum    = 12'(force_scaled) * 12'd3 + 12'(force_ff) * 12'd7;
   assign force_prod   = 25'(force_sum) * RECIP_TEN;
   assign force_new    = force_prod[23:16];
   assign grab_hit     = (mode_ff == MODE_CLOSING) && (force_new > FORCE_THRESH)
                         && running_ff;
   assign grab_drop    = holding_ff && (force_new < FORCE_THRESH) && !running_ff;
   assign mode_eff     = grab_hit ? MODE_HELD : mode_ff;

   assign status.need_ramp = (type_ff == REQ_TICK) && running_ff &&
                             ((mode_eff == MODE_OPENING) || (mode_eff == MODE_CLOSING) ||
                              (mode_eff == MODE_REOPEN));
   assign status.div_done  = div_done;

   // Elapsed time and saturation check against 181 full periods
   assign elapsed     = now_ff - start_ff;
   assign elapsed_ext = CMP_W'(elapsed);
   assign sat_limit   = 24'(period_ff) * SAT_Q;
   assign span        = (max_ff > min_ff) ? (max_ff - min_ff) : 8'd0;

   grfs_div #(
      .NUM_W (PROD_W),
      .DEN_W (PERIOD_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (prod_ff),
      .denom (period_ff),
      .quot  (quot),
      .done  (div_done)
   );

   // Ramp step, offset from the base, clamp to the limits
   assign step = sat_ff ? STEP_MAX :
                 ((quot > PROD_W'(STEP_MAX)) ? STEP_MAX : quot[7:0]);

   always_comb begin
      case (mode_ff)
         MODE_OPENING: base = closed_ff;
         MODE_CLOSING: base = open_ff;
         default:      base = saved_ff;
      endcase
   end

   assign ramp_x = dir_up_ff ? ($signed({2'b00, base}) + $signed({2'b00, step}))
                             : ($signed({2'b00, base}) - $signed({2'b00, step}));

   always_comb begin
      if (ramp_x < $signed({2'b00, min_ff})) begin
         angle = min_ff;
      end else if (ramp_x > $signed({2'b00, max_ff})) begin
         angle = max_ff;
      end else begin
         angle = ramp_x[7:0];
      end
   end

   // Next-state logic for all registers
   always_comb begin
      min_in       = min_ff;
      max_in       = max_ff;
      closed_in    = closed_ff;
      open_in      = open_ff;
      period_in    = period_ff;
      mode_in      = mode_ff;
      running_in   = running_ff;
      dir_up_in    = dir_up_ff;
      holding_in   = holding_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      saved_in     = saved_ff;
      force_in     = force_ff;
      type_in      = type_ff;
      now_in       = now_ff;
      fsr_in       = fsr_ff;
      prod_in      = prod_ff;
      sat_in       = sat_ff;
      cmd_in       = cmd_ff;
      wrote_in     = wrote_ff;
      out_angle_in = out_angle_ff;
      out_wrote_in = out_wrote_ff;
      out_grab_in  = out_grab_ff;
      out_mode_in  = out_mode_ff;
      out_run_in   = out_run_ff;
      out_force_in = out_force_ff;

      // Register writes; a zero period falls back to the default
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_ANGLE:    min_in    = csr_wdata[7:0];
            CSR_MAX_ANGLE:    max_in    = csr_wdata[7:0];
            CSR_CLOSED_ANGLE: closed_in = csr_wdata[7:0];
            CSR_OPEN_ANGLE:   open_in   = csr_wdata[7:0];
            CSR_RAMP_PERIOD:  period_in = (csr_wdata == '0) ? PERIOD_DEFAULT
                                                             : csr_wdata;
            default: ;
         endcase
      end

      // Capture the accepted item
      if (cmd.capture) begin
         type_in = req_type;
         now_in  = TIME_BITS'(req_now_ms);
         fsr_in  = req_fsr_raw;
      end

      // Commands, force update and the non-ramp sequencer steps
      if (cmd.exec) begin
         wrote_in = 1'b0;
         cmd_in   = last_ff;
         case (type_ff)
            REQ_TICK: begin
               force_in = force_new;
               if (grab_hit) begin
                  holding_in = 1'b1;
                  mode_in    = MODE_HELD;
               end else if (grab_drop) begin
                  holding_in = 1'b0;
               end
               if (running_ff) begin
                  case (mode_eff)
                     MODE_START: begin
                        mode_in   = MODE_OPENING;
                        cmd_in    = closed_ff;
                        wrote_in  = 1'b1;
                        start_in  = now_ff;
                        dir_up_in = 1'b0;
                     end
                     MODE_HELD: begin
                        cmd_in     = last_ff;
                        wrote_in   = 1'b1;
                        running_in = 1'b0;
                        holding_in = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            REQ_OPEN: begin
               running_in = 1'b1;
               mode_in    = MODE_START;
            end
            REQ_CLOSE: begin
               running_in = 1'b1;
               mode_in    = MODE_CLOSING;
               dir_up_in  = 1'b1;
               start_in   = now_ff;
            end
            default: begin
               mode_in    = MODE_REOPEN;
               dir_up_in  = 1'b0;
               saved_in   = last_ff;
               running_in = 1'b1;
               start_in   = now_ff;
               holding_in = 1'b0;
            end
         endcase
      end

      // Register span * elapsed and the saturation flag
      if (cmd.mul_load) begin
         prod_in = PROD_W'(span) * PROD_W'(elapsed_ext[ELAP_W-1:0]);
         sat_in  = (elapsed_ext >= CMP_W'(sat_limit)) && (span != 8'd0);
      end

      // Command the ramp angle and check the end of the ramp
      if (cmd.angle_apply) begin
         wrote_in = 1'b1;
         cmd_in   = angle;
         last_in  = angle;
         case (mode_ff)
            MODE_OPENING: begin
               if ((dir_up_ff && (angle >= open_ff)) ||
                   (!dir_up_ff && (angle <= open_ff))) begin
                  running_in = 1'b0;
               end
            end
            MODE_CLOSING: begin
               if (dir_up_ff && (angle >= closed_ff)) begin
                  mode_in    = MODE_START;
                  running_in = 1'b0;
                  start_in   = now_ff;
               end
            end
            default: begin
               if (!dir_up_ff && (angle <= open_ff)) begin
                  mode_in   = MODE_CLOSING;
                  start_in  = now_ff;
                  dir_up_in = 1'b1;
               end
            end
         endcase
      end

      // Load the result from the updated state
      if (cmd.out_load) begin
         out_angle_in = wrote_ff ? cmd_ff : last_ff;
         out_wrote_in = wrote_ff;
         out_grab_in  = holding_ff;
         out_mode_in  = mode_ff;
         out_run_in   = running_ff;
         out_force_in = force_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= MIN_ANGLE_RST;
         max_ff     <= MAX_ANGLE_RST;
         closed_ff  <= CLOSED_ANGLE_RST;
         open_ff    <= OPEN_ANGLE_RST;
         period_ff  <= PERIOD_DEFAULT;
         mode_ff    <= MODE_START;
         running_ff <= 1'b0;
         dir_up_ff  <= 1'b0;
         holding_ff <= 1'b0;
         start_ff   <= '0;
         last_ff    <= '0;
         saved_ff   <= '0;
         force_ff   <= '0;
      end else begin
         min_ff     <= min_in;
         max_ff     <= max_in;
         closed_ff  <= closed_in;
         open_ff    <= open_in;
         period_ff  <= period_in;
         mode_ff    <= mode_in;
         running_ff <= running_in;
         dir_up_ff  <= dir_up_in;
         holding_ff <= holding_in;
         start_ff   <= start_in;
         last_ff    <= last_in;
         saved_ff   <= saved_in;
         force_ff   <= force_in;
      end
      type_ff      <= type_in;
      now_ff       <= now_in;
      fsr_ff       <= fsr_in;
      prod_ff      <= prod_in;
      sat_ff       <= sat_in;
      cmd_ff       <= cmd_in;
      wrote_ff     <= wrote_in;
      out_angle_ff <= out_angle_in;
      out_wrote_ff <= out_wrote_in;
      out_grab_ff  <= out_grab_in;
      out_mode_ff  <= out_mode_in;
      out_run_ff   <= out_run_in;
      out_force_ff <= out_force_in;
   end

   assign rsp_servo_angle   = out_angle_ff;
   assign rsp_angle_written = out_wrote_ff;
   assign rsp_grabbed       = out_grab_ff;
   assign rsp_mode_now      = out_mode_ff;
   assign rsp_motion_active = out_run_ff;
   assign rsp_force_level   = out_force_ff;

endmodule

>>> rtl/gripper_ramp_with_force_stop_core.sv
// Top level of the gripper ramp sequencer with force stop.
// Depends on grfs_pkg, grfs_ctrl and grfs_dp (which holds grfs_div).
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_type, req_now_ms, req_fsr_raw
// rsp      out        rsp_valid / rsp_ready  servo_angle, angle_written, grabbed,
//                                            mode_now, motion_active, force_level
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One item at a time. A command, or a tick that needs no ramp angle, goes through
// the execute and result steps after acceptance; a ramp tick adds multiply, divide
// and angle steps; the 32-step serial divider splits span*elapsed by the ramp period.
// req_ready rises again at the same edge that loads the result into the output
// register; a stalled rsp channel holds the block in its final step.
// Synchronous reset restores register defaults and clears the sequencer state.
// csr_ready is always high.
`timescale 1ns / 1ps

module gripper_ramp_with_force_stop_core
   import grfs_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [31:0]           req_now_ms,
   input  logic [9:0]            req_fsr_raw,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_servo_angle,
   output logic                  rsp_angle_written,
   output logic                  rsp_grabbed,
   output logic [2:0]            rsp_mode_now,
   output logic                  rsp_motion_active,
   output logic [7:0]            rsp_force_level,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Register writes are taken at once
   assign csr_ready = 1'b1;

   grfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   grfs_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_now_ms        (req_now_ms),
      .req_fsr_raw       (req_fsr_raw),
      .rsp_servo_angle   (rsp_servo_angle),
      .rsp_angle_written (rsp_angle_written),
      .rsp_grabbed       (rsp_grabbed),
      .rsp_mode_now      (rsp_mode_now),
      .rsp_motion_active (rsp_motion_active),
      .rsp_force_level   (rsp_force_level)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for gripper_ramp_with_force_stop_core.
// Depends on grfs_pkg and the core RTL. A scoreboard class predicts every
// response from the accepted requests and the register settings.
`timescale 1ns / 1ps

module tb_top;
   import grfs_pkg::*;

   localparam int LIMIT_CYCLES      = 1000000;
   localparam int CSR_NUM_REGS      = 5;
   localparam int NUM_SETTINGS      = 6;
   localparam int ITEMS_PER_SETTING = 275;
   localparam int SETTLE_CYCLES     = 8;
   localparam int DRAIN_CYCLES      = 60;
   localparam int HOLD_OFF_CYCLES   = 400;

   typedef struct packed {
      logic [7:0] angle;
      logic       written;
      logic       grabbed;
      logic [2:0] mode;
      logic       active;
      logic [7:0] force_lvl;
   } grip_rsp_t;

   // Response predictor plus the queue of responses still owed by the core
   class grip_scoreboard;
      logic [7:0]  min_a, max_a, closed_a, open_a;
      logic [15:0] period;
      logic [2:0]  mode;
      bit          running, dir_up, holding;
      logic [31:0] start_ms;
      logic [7:0]  last_angle, saved_angle, force_avg;
      grip_rsp_t   expected_rsp[$];
      int          errors;

      function new();
         min_a       = MIN_ANGLE_RST;
         max_a       = MAX_ANGLE_RST;
         closed_a    = CLOSED_ANGLE_RST;
         open_a      = OPEN_ANGLE_RST;
         period      = PERIOD_DEFAULT;
         mode        = MODE_START;
         running     = 1'b0;
         dir_up      = 1'b0;
         holding     = 1'b0;
         start_ms    = '0;
         last_angle  = '0;
         saved_angle = '0;
         force_avg   = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MIN_ANGLE:    min_a    = data[7:0];
            CSR_MAX_ANGLE:    max_a    = data[7:0];
            CSR_CLOSED_ANGLE: closed_a = data[7:0];
            CSR_OPEN_ANGLE:   open_a   = data[7:0];
            CSR_RAMP_PERIOD:  period   = (data == '0) ? PERIOD_DEFAULT : data;
            default: ;
         endcase
      endfunction

      // Angle travelled after elapsed ms, saturating at a full sweep
      function logic [7:0] ramp_offset(logic [31:0] elapsed);
         longint unsigned span, q, r, v;
         if (max_a <= min_a) return '0;
         span = max_a - min_a;
         q = elapsed / period;
         r = elapsed % period;
         if (q > STEP_MAX) return STEP_MAX;
         v = span * q + (span * r) / period;
         if (v > STEP_MAX) return STEP_MAX;
         return v[7:0];
      endfunction

      // Move from base in the ramp direction, then clamp low limit first
      function logic [7:0] ramp_target(logic [7:0] base, logic [31:0] elapsed);
         int step, x;
         step = int'(ramp_offset(elapsed));
         x = dir_up ? int'(base) + step : int'(base) - step;
         if (x < int'(min_a)) return min_a;
         if (x > int'(max_a)) return max_a;
         return x[7:0];
      endfunction

      // Scale the sample, smooth it and apply the grab and release rules
      function void filter_force(logic [9:0] raw);
         int scaled, s;
         scaled = int'(raw) * 255 / 1024;
         s = (3 * scaled + 7 * int'(force_avg)) / 10;
         if (mode == MODE_CLOSING && s > int'(FORCE_THRESH) && running) begin
            holding = 1'b1;
            mode    = MODE_HELD;
         end else if (holding && s < int'(FORCE_THRESH) && !running) begin
            holding = 1'b0;
         end
         force_avg = s[7:0];
      endfunction

      function void note_request(logic [1:0] kind, logic [31:0] now, logic [9:0] raw);
         grip_rsp_t   r;
         logic [31:0] elapsed;
         logic [7:0]  cmd;
         bit          wrote;
         wrote = 1'b0;
         cmd   = '0;
         case (kind)
            REQ_TICK: begin
               filter_force(raw);
               if (running) begin
                  elapsed = now - start_ms;
                  case (mode)
                     MODE_START: begin
                        mode     = MODE_OPENING;
                        cmd      = closed_a;
                        wrote    = 1'b1;
                        start_ms = now;
                        dir_up   = 1'b0;
                     end
                     MODE_OPENING: begin
                        cmd        = ramp_target(closed_a, elapsed);
                        wrote      = 1'b1;
                        last_angle = cmd;
                        if ((dir_up && cmd >= open_a) || (!dir_up && cmd <= open_a))
                           running = 1'b0;
                     end
                     MODE_CLOSING: begin
                        cmd        = ramp_target(open_a, elapsed);
                        wrote      = 1'b1;
                        last_angle = cmd;
                        if (dir_up && cmd >= closed_a) begin
                           mode     = MODE_START;
                           running  = 1'b0;
                           start_ms = now;
                        end
                     end
                     MODE_HELD: begin
                        cmd     = last_angle;
                        wrote   = 1'b1;
                        running = 1'b0;
                        holding = 1'b1;
                     end
                     MODE_REOPEN: begin
                        cmd        = ramp_target(saved_angle, elapsed);
                        wrote      = 1'b1;
                        last_angle = cmd;
                        if (!dir_up && cmd <= open_a) begin
                           mode     = MODE_CLOSING;
                           start_ms = now;
                           dir_up   = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            REQ_OPEN: begin
               running = 1'b1;
               mode    = MODE_START;
            end
            REQ_CLOSE: begin
               running  = 1'b1;
               mode     = MODE_CLOSING;
               dir_up   = 1'b1;
               start_ms = now;
            end
            REQ_RESET: begin
               mode        = MODE_REOPEN;
               dir_up      = 1'b0;
               saved_angle = last_angle;
               running     = 1'b1;
               start_ms    = now;
               holding     = 1'b0;
            end
            default: ;
         endcase
         r.angle     = wrote ? cmd : last_angle;
         r.written   = wrote;
         r.grabbed   = holding;
         r.mode      = mode;
         r.active    = running;
         r.force_lvl = force_avg;
         expected_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(grip_rsp_t got);
         grip_rsp_t want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response with no request pending, expected none, actual %p",
                     $time, got);
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("servo_angle", want.angle, got.angle);
         compare_field("angle_written", want.written, got.written);
         compare_field("grabbed", want.grabbed, got.grabbed);
         compare_field("mode_now", want.mode, got.mode);
         compare_field("motion_active", want.active, got.active);
         compare_field("force_level", want.force_lvl, got.force_lvl);
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction
   endclass

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_type          = REQ_TICK;
   logic [31:0]           req_now_ms        = '0;
   logic [9:0]            req_fsr_raw       = '0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic [7:0]            rsp_servo_angle;
   logic                  rsp_angle_written;
   logic                  rsp_grabbed;
   logic [2:0]            rsp_mode_now;
   logic                  rsp_motion_active;
   logic [7:0]            rsp_force_level;
   logic                  csr_valid         = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index         = '0;
   logic [CSR_DATA_W-1:0] csr_wdata         = '0;

   grip_scoreboard sb;
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;
   logic           hold_off    = 1'b0;
   bit             pressure_go = 1'b0;
   int             cycle_count = 0;
   logic [31:0]    ms_now      = '0;
   int             step_max    = 200;

   gripper_ramp_with_force_stop_core i_dut (.*);

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("[gripper_ramp_with_force_stop_core] ERROR");
         $finish;
      end
   end

   // Stall the response channel at random, or fully during a hold-off
   always @(negedge clock) begin
      rsp_ready <= !hold_off && ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(grip_rsp_t'{rsp_servo_angle, rsp_angle_written, rsp_grabbed,
                                       rsp_mode_now, rsp_motion_active, rsp_force_level});
   end

   // Hold off the receiver for a long stretch so the core backs up its input
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // Offer one item, with random idle cycles ahead of it; entered at a falling edge
   task automatic push_item(logic [1:0] kind, logic [31:0] now, logic [9:0] raw);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_now_ms  <= now;
      req_fsr_raw <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, now, raw);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed response is back
   task automatic drain_block();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_setting(int idx);
      logic [CSR_DATA_W-1:0] vals [CSR_NUM_REGS];
      case (idx)
         0: vals = '{16'd0, 16'd180, 16'd90, 16'd0, 16'd1000};
         1: vals = '{16'd0, 16'd180, 16'd180, 16'd0, 16'd1};
         2: vals = '{16'd180, 16'd0, 16'd100, 16'd50, 16'd0};
         3: vals = '{16'd60, 16'd60, 16'd60, 16'd60, 16'hFFFF};
         4: vals = '{CSR_DATA_W'($urandom_range(0, 180)), CSR_DATA_W'($urandom_range(0, 180)),
                     CSR_DATA_W'($urandom_range(0, 180)), CSR_DATA_W'($urandom_range(0, 180)),
                     CSR_DATA_W'($urandom_range(1, 3000))};
         default: vals = '{16'd10, 16'd170, 16'd0, 16'd180, 16'd300};
      endcase
      write_reg(CSR_MIN_ANGLE, vals[0]);
      write_reg(CSR_MAX_ANGLE, vals[1]);
      write_reg(CSR_CLOSED_ANGLE, vals[2]);
      write_reg(CSR_OPEN_ANGLE, vals[3]);
      write_reg(CSR_RAMP_PERIOD, vals[4]);
      // unused index must leave every register alone
      write_reg(CSR_IDX_W'($urandom_range(CSR_NUM_REGS, (1 << CSR_IDX_W) - 1)),
                CSR_DATA_W'($urandom()));
      csr_valid <= 1'b0;
      step_max = int'(sb.period) / 5 + 1;
   endtask

   // Boundary values, every command and the grab, release and wrap cases
   task automatic run_directed();
      push_item(REQ_TICK, 32'd0, 10'd0);
      push_item(REQ_TICK, 32'd0, 10'h3FF);
      push_item(REQ_TICK, 32'd0, 10'd0);
      push_item(REQ_OPEN, 32'd100, 10'd0);
      push_item(REQ_TICK, 32'd100, 10'd0);
      push_item(REQ_TICK, 32'd350, 10'd0);
      push_item(REQ_TICK, 32'd5000, 10'd0);
      push_item(REQ_CLOSE, 32'd6000, 10'd0);
      push_item(REQ_TICK, 32'd6250, 10'd0);
      push_item(REQ_TICK, 32'd6300, 10'h3FF);
      push_item(REQ_TICK, 32'd6400, 10'h3FF);
      repeat (5) push_item(REQ_TICK, 32'd6500, 10'd0);
      push_item(REQ_RESET, 32'd7000, 10'd0);
      push_item(REQ_TICK, 32'd7100, 10'd0);
      push_item(REQ_TICK, 32'd9000, 10'd0);
      push_item(REQ_TICK, 32'd9500, 10'd0);
      push_item(REQ_TICK, 32'd20000, 10'd0);
      push_item(REQ_CLOSE, 32'hFFFF_FF00, 10'd0);
      push_item(REQ_TICK, 32'h0000_0100, 10'd0);
      push_item(REQ_CLOSE, 32'd0, 10'd0);
      push_item(REQ_TICK, 32'hFFFF_FFFF, 10'd0);
   endtask

   // A command, or none, followed by a run of ticks with mostly advancing time, plus some noise
   task automatic run_random(int n_items);
      int          sent, kind, len, profile, lvl;
      logic [9:0]  raw;
      sent = 0;
      while (sent < n_items) begin
         kind    = $urandom_range(0, 9);
         len     = $urandom_range(2, 14);
         profile = $urandom_range(0, 2);
         if (kind == 9) begin
            repeat ($urandom_range(1, 4)) begin
               push_item(2'($urandom_range(0, 3)), $urandom(), 10'($urandom_range(0, 1023)));
               sent++;
            end
         end else begin
            if (kind < 8) begin
               if (kind <= 2)
                  push_item(REQ_OPEN, ms_now, 10'($urandom_range(0, 1023)));
               else if (kind <= 5)
                  push_item(REQ_CLOSE, ms_now, 10'($urandom_range(0, 1023)));
               else
                  push_item(REQ_RESET, ms_now, 10'($urandom_range(0, 1023)));
               sent++;
            end
            for (int i = 1; i <= len; i++) begin
               if ($urandom_range(0, 24) == 0)
                  ms_now = $urandom();
               else
                  ms_now += $urandom_range(0, step_max);
               case (profile)
                  0: raw = 10'($urandom_range(0, 150));
                  1: begin
                     lvl = i * int'($urandom_range(40, 160));
                     raw = (lvl > 1023) ? 10'h3FF : 10'(lvl);
                  end
                  default: raw = 10'($urandom_range(0, 1023));
               endcase
               push_item(REQ_TICK, ms_now, raw);
               sent++;
            end
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         drain_block();
         case (s / 2)
            0: begin
               tx_idle_pct = 27;
               rx_idle_pct = 77;
            end
            1: begin
               tx_idle_pct = 77;
               rx_idle_pct = 27;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         load_setting(s);
         if (s == NUM_SETTINGS - 2) pressure_go = 1'b1;
         run_random(ITEMS_PER_SETTING);
      end
      drain_block();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("[gripper_ramp_with_force_stop_core] OK");
      else
         $display("[gripper_ramp_with_force_stop_core] ERROR");
      $finish;
   end

endmodule
